>>> rtl/core/scld_pkg.sv
// Serial command line decoder: shared types, character codes and match helpers.
// No dependencies; imported by scld_decode and serial_command_line_decoder.
`timescale 1ns / 1ps

package scld_pkg;

  typedef enum logic [2:0] {
    KIND_ON       = 3'd0,
    KIND_OFF      = 3'd1,
    KIND_BLINK    = 3'd2,
    KIND_FREQ     = 3'd3,
    KIND_MODL     = 3'd4,
    KIND_SYNTAX   = 3'd5,
    KIND_OVERFLOW = 3'd6
  } scld_kind_e;

  typedef struct packed {
    scld_kind_e  kind;
    logic [15:0] value;
  } scld_result_t;

  typedef struct packed {
    logic [15:0] pulse;
    logic [15:0] freq;
    logic [15:0] mod;
  } scld_limits_t;

  // Register indexes on the config port
  localparam logic [1:0] REG_PULSE_LIMIT = 2'd0;
  localparam logic [1:0] REG_FREQ_LIMIT  = 2'd1;
  localparam logic [1:0] REG_MOD_LIMIT   = 2'd2;

  localparam logic [15:0] PULSE_LIMIT_RST = 16'd1000;
  localparam logic [15:0] FREQ_LIMIT_RST  = 16'd1000;
  localparam logic [15:0] MOD_LIMIT_RST   = 16'd100;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  localparam logic [5:0] TEXT_SAT = 6'd63;

  // Keywords, right aligned: the last letter sits in bits 7:0
  localparam logic [39:0] WORD_ON    = 40'("on");
  localparam logic [39:0] WORD_OFF   = 40'("off");
  localparam logic [39:0] WORD_BLINK = 40'("blink");
  localparam logic [39:0] WORD_FREQ  = 40'("freq");
  localparam logic [39:0] WORD_MODL  = 40'("modl");

  localparam logic [2:0] LEN_ON    = 3'd2;
  localparam logic [2:0] LEN_OFF   = 3'd3;
  localparam logic [2:0] LEN_BLINK = 3'd5;
  localparam logic [2:0] LEN_FREQ  = 3'd4;
  localparam logic [2:0] LEN_MODL  = 3'd4;

  // True if a keyword candidate survives byte b at text position pos.
  // Exact words die on any byte past their end; prefixes live on.
  function automatic logic word_keep(logic [39:0] word, logic [2:0] len, logic exact,
                                     logic [5:0] pos, logic [7:0] b);
    logic [5:0]  sh;
    logic [39:0] shifted;
    sh      = {len - 3'd1 - pos[2:0], 3'b000};
    shifted = word >> sh;
    if (pos < {3'b000, len}) begin
      return shifted[7:0] == b;
    end
    return !exact;
  endfunction

  // Signed 32-bit compare of the argument against [lo, limit]
  function automatic logic arg_in_range(logic [31:0] acc, logic lo_one, logic [15:0] limit);
    return !acc[31] && (acc >= {31'b0, lo_one}) && (acc <= {16'b0, limit});
  endfunction

endpackage

>>> rtl/core/scld_decode.sv
// Per-byte line state (trim flag, counters, keyword candidates, argument) and
// the end-of-line decision. Depends on scld_pkg.
`timescale 1ns / 1ps

module scld_decode import scld_pkg::*; #(
  parameter int LINE_MAX = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  input  scld_limits_t limits_i,
  output scld_result_t res_o
);

  localparam int LC_W = $clog2(LINE_MAX + 1);

  logic            trimming_q, trimming_d;
  logic [LC_W-1:0] line_count_q, line_count_d;
  logic [5:0]      text_count_q, text_count_d;
  logic [4:0]      alive_q, alive_d;
  logic [31:0]     acc_q, acc_d;
  logic            overflowed_q, overflowed_d;

  logic            is_cr;
  logic            is_blank;
  logic            line_full;
  logic [31:0]     acc_x10;
  logic [4:0]      keep;

  assign is_cr     = byte_i == CHAR_CR;
  assign is_blank  = (byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB);
  assign line_full = line_count_q == LC_W'(LINE_MAX);
  assign acc_x10   = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0};

  assign keep[0] = word_keep(WORD_ON,    LEN_ON,    1'b1, text_count_q, byte_i);
  assign keep[1] = word_keep(WORD_OFF,   LEN_OFF,   1'b1, text_count_q, byte_i);
  assign keep[2] = word_keep(WORD_BLINK, LEN_BLINK, 1'b0, text_count_q, byte_i);
  assign keep[3] = word_keep(WORD_FREQ,  LEN_FREQ,  1'b0, text_count_q, byte_i);
  assign keep[4] = word_keep(WORD_MODL,  LEN_MODL,  1'b0, text_count_q, byte_i);

  always_comb begin
    trimming_d   = trimming_q;
    line_count_d = line_count_q;
    text_count_d = text_count_q;
    alive_d      = alive_q;
    acc_d        = acc_q;
    overflowed_d = overflowed_q;

    if (line_full) begin
      overflowed_d = 1'b1;
    end else begin
      line_count_d = line_count_q + LC_W'(1);
    end

    if (is_cr) begin
      trimming_d   = 1'b1;
      line_count_d = '0;
      text_count_d = '0;
      alive_d      = '1;
      acc_d        = '0;
      overflowed_d = 1'b0;
    end else if (!(trimming_q && is_blank)) begin
      trimming_d = 1'b0;
      alive_d    = alive_q & keep;
      if (text_count_q != TEXT_SAT) begin
        text_count_d = text_count_q + 6'd1;
      end
      if (byte_i == CHAR_SPACE) begin
        acc_d = '0;
      end else begin
        acc_d = acc_x10 + {24'b0, byte_i} - {24'b0, CHAR_ZERO};
      end
    end
  end

  // End-of-line decision from the state the line left behind
  always_comb begin
    res_o.kind  = KIND_SYNTAX;
    res_o.value = '0;
    if (overflowed_q || line_full) begin
      res_o.kind = KIND_OVERFLOW;
    end else if (alive_q[0] && text_count_q == 6'd2) begin
      res_o.kind = KIND_ON;
    end else if (alive_q[1] && text_count_q == 6'd3) begin
      res_o.kind = KIND_OFF;
    end else if (alive_q[2] && text_count_q >= 6'd5) begin
      if (arg_in_range(acc_q, 1'b1, limits_i.pulse)) begin
        res_o.kind  = KIND_BLINK;
        res_o.value = acc_q[15:0];
      end
    end else if (alive_q[3] && text_count_q >= 6'd4) begin
      if (arg_in_range(acc_q, 1'b1, limits_i.freq)) begin
        res_o.kind  = KIND_FREQ;
        res_o.value = acc_q[15:0];
      end
    end else if (alive_q[4] && text_count_q >= 6'd4) begin
      if (arg_in_range(acc_q, 1'b0, limits_i.mod)) begin
        res_o.kind  = KIND_MODL;
        res_o.value = acc_q[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trimming_q   <= 1'b1;
      line_count_q <= '0;
      text_count_q <= '0;
      alive_q      <= '1;
      acc_q        <= '0;
      overflowed_q <= 1'b0;
    end else if (step_i) begin
      trimming_q   <= trimming_d;
      line_count_q <= line_count_d;
      text_count_q <= text_count_d;
      alive_q      <= alive_d;
      acc_q        <= acc_d;
      overflowed_q <= overflowed_d;
    end
  end

  a_cr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_cr) |=> (trimming_q && line_count_q == '0 && !overflowed_q))
    else $error("line state not cleared after carriage return");

  a_text_after_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_count_q != 6'd0) |-> !trimming_q)
    else $error("text counted while still trimming");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflowed_q |-> line_full)
    else $error("overflow flag set on a line that is not full");

endmodule

>>> rtl/core/serial_command_line_decoder.sv
// Serial command line decoder, top level: input beat register, limit registers,
// result register. Depends on scld_pkg and scld_decode.
//
//   port group   dir  width  contents
//   s_axis_*     in   8      rx_byte
//   m_axis_*     out  24     cmd_kind [2:0], cmd_value [18:3], zero [23:19]
//   cfg_*        in   2/16   limit register writes (0 pulse, 1 freq, 2 mod)
//
// One byte per cycle sustained while no carriage return waits on a held result. A carriage
// return's result passes the input register, then the result register.
// Reset brings the limits to 1000/1000/100 and an empty line; no clearing pass.
// A held result stalls only carriage returns; other bytes keep flowing past it.
`timescale 1ns / 1ps

module serial_command_line_decoder import scld_pkg::*; #(
  parameter int LINE_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] cmd_kind, [18:3] cmd_value, rest zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_cr;
  logic         in_go;
  logic         out_valid_q;
  scld_result_t out_res_q;
  scld_result_t res;
  scld_limits_t limits_q;

  assign in_cr = in_byte_q == CHAR_CR;
  // Only a carriage return needs the result slot free
  assign in_go = in_valid_q && (!in_cr || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || in_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.pulse <= PULSE_LIMIT_RST;
      limits_q.freq  <= FREQ_LIMIT_RST;
      limits_q.mod   <= MOD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PULSE_LIMIT: limits_q.pulse <= cfg_data_i;
        REG_FREQ_LIMIT:  limits_q.freq  <= cfg_data_i;
        REG_MOD_LIMIT:   limits_q.mod   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scld_decode #(
    .LINE_MAX (LINE_MAX)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_go),
    .byte_i   (in_byte_q),
    .limits_i (limits_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_go && in_cr) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_cr) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.value, out_res_q.kind};

  a_cr_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_go && in_cr) |=> out_valid_q)
    else $error("carriage return left no result");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.kind == KIND_ON || out_res_q.kind == KIND_OFF ||
     out_res_q.kind == KIND_SYNTAX || out_res_q.kind == KIND_OVERFLOW))
    |-> out_res_q.value == 16'd0)
    else $error("nonzero value on a result without argument");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_go) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input beat lost or changed");

endmodule

>>> dv/scld_line_checker.sv
// Checker for the serial command line decoder: follows input and result beats,
// predicts each line's command and compares. Depends on scld_pkg.
`timescale 1ns / 1ps

module scld_line_checker import scld_pkg::*; #(
  parameter int LINE_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [2:0] cmd_kind, [18:3] cmd_value, rest zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  scld_limits_t lim;

  // Line decode state
  logic        skip_lead;
  logic [6:0]  line_len;
  logic [5:0]  text_len;
  logic [4:0]  word_live;
  logic [31:0] arg_acc;
  logic        too_long;

  scld_result_t pending_cmds[$];
  int           fails;
  int           checked;

  // Keyword text, indexed by the command kind that it yields
  function automatic string word_of(input scld_kind_e k);
    case (k)
      KIND_ON:    return "on";
      KIND_OFF:   return "off";
      KIND_BLINK: return "blink";
      KIND_FREQ:  return "freq";
      default:    return "modl";
    endcase
  endfunction

  function automatic logic arg_ok(input logic [31:0] a, input logic [31:0] lo,
                                  input logic [15:0] cap);
    return !a[31] && (a >= lo) && (a <= {16'b0, cap});
  endfunction

  task automatic clear_line();
    skip_lead = 1'b1;
    line_len  = '0;
    text_len  = '0;
    word_live = '1;
    arg_acc   = '0;
    too_long  = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    string        w;
    scld_result_t r;
    // the CR counts toward the line length too
    if (line_len >= LINE_MAX) too_long = 1'b1;
    else line_len++;

    if (b != CHAR_CR) begin
      if (skip_lead && (b == CHAR_SPACE || b == CHAR_TAB)) return;
      skip_lead = 1'b0;
      for (int k = KIND_ON; k <= KIND_MODL; k++) begin
        w = word_of(scld_kind_e'(k));
        if (text_len < w.len()) begin
          if (8'(w[text_len]) != b) word_live[k] = 1'b0;
        end else if (k <= KIND_OFF) begin
          word_live[k] = 1'b0;
        end
      end
      if (text_len != TEXT_SAT) text_len++;
      // a space restarts the argument; everything else accumulates, wrapping
      if (b == CHAR_SPACE) arg_acc = '0;
      else arg_acc = arg_acc * 32'd10 + {24'b0, b} - 32'd48;
      return;
    end

    r.kind  = KIND_SYNTAX;
    r.value = '0;
    if (too_long) begin
      r.kind = KIND_OVERFLOW;
    end else if (word_live[KIND_ON] && text_len == word_of(KIND_ON).len()) begin
      r.kind = KIND_ON;
    end else if (word_live[KIND_OFF] && text_len == word_of(KIND_OFF).len()) begin
      r.kind = KIND_OFF;
    end else if (word_live[KIND_BLINK] && text_len >= word_of(KIND_BLINK).len()) begin
      if (arg_ok(arg_acc, 32'd1, lim.pulse)) begin
        r.kind  = KIND_BLINK;
        r.value = arg_acc[15:0];
      end
    end else if (word_live[KIND_FREQ] && text_len >= word_of(KIND_FREQ).len()) begin
      if (arg_ok(arg_acc, 32'd1, lim.freq)) begin
        r.kind  = KIND_FREQ;
        r.value = arg_acc[15:0];
      end
    end else if (word_live[KIND_MODL] && text_len >= word_of(KIND_MODL).len()) begin
      if (arg_ok(arg_acc, 32'd0, lim.mod)) begin
        r.kind  = KIND_MODL;
        r.value = arg_acc[15:0];
      end
    end
    pending_cmds.push_back(r);
    clear_line();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scld_result_t want;
    logic [2:0]   got_kind;
    logic [15:0]  got_val;
    if (!rst_ni) begin
      lim = '{PULSE_LIMIT_RST, FREQ_LIMIT_RST, MOD_LIMIT_RST};
      clear_line();
      pending_cmds.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PULSE_LIMIT: lim.pulse = cfg_data_i;
          REG_FREQ_LIMIT:  lim.freq  = cfg_data_i;
          REG_MOD_LIMIT:   lim.mod   = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_kind = m_axis_tdata[2:0];
        got_val  = m_axis_tdata[18:3];
        if (pending_cmds.size() == 0) begin
          fails++;
          $display("%0t: result beat with none expected: kind %0d value %0d",
                   $time, got_kind, got_val);
        end else begin
          want = pending_cmds.pop_front();
          checked++;
          if (got_kind != want.kind) begin
            fails++;
            $display("%0t: cmd_kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, got_kind);
          end
          if (got_val != want.value) begin
            fails++;
            $display("%0t: cmd_value mismatch: expected %0d, actual %0d",
                     $time, want.value, got_val);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
    end
    fail_count_o <= fails;
    pending_o    <= pending_cmds.size();
    results_o    <= checked;
  end

endmodule

>>> dv/tb_serial_command_line_decoder.sv
// Testbench top for the serial command line decoder: clock, reset, byte stimulus,
// limit writes and result back-pressure. Depends on scld_pkg, the DUT and scld_line_checker.
`timescale 1ns / 1ps

module tb_serial_command_line_decoder;
  import scld_pkg::*;

  localparam int         LINE_MAX     = 32;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 4;
  localparam int         PHASE_BYTES  = 190;
  localparam int         PHASES       = 5;
  localparam logic [1:0] REG_SPARE    = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  int fail_count;
  int pending;
  int results;

  int cycles      = 0;
  int bytes_sent  = 0;
  int lines_sent  = 0;
  int settings    = 1;
  int burst_left  = 0;
  int phase_start = 0;
  int hold_req    = 0;
  bit steady_tx   = 1'b0;

  // receiver stall state
  int          hold_served = 0;
  int          hold_left   = 0;
  int          pat_age     = 0;
  logic [15:0] rdy_pat     = '1;

  scld_limits_t lim_now = '{PULSE_LIMIT_RST, FREQ_LIMIT_RST, MOD_LIMIT_RST};

  serial_command_line_decoder #(.LINE_MAX(LINE_MAX)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  scld_line_checker #(.LINE_MAX(LINE_MAX)) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: rotating ready pattern, re-rolled now and then; a request
  // from the stimulus starts one long hold-off.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(16, 80);
        case ($urandom_range(0, 3))
          0:       rdy_pat = '1;
          1:       rdy_pat = 16'($urandom);
          2:       rdy_pat = 16'($urandom | $urandom);
          default: rdy_pat = 16'($urandom & $urandom);
        endcase
      end
      pat_age--;
      rdy_pat = {rdy_pat[14:0], rdy_pat[15]};
      m_axis_tready <= rdy_pat[0];
    end
  end

  function automatic string word_of(input scld_kind_e k);
    case (k)
      KIND_ON:    return "on";
      KIND_OFF:   return "off";
      KIND_BLINK: return "blink";
      KIND_FREQ:  return "freq";
      default:    return "modl";
    endcase
  endfunction

  function automatic logic [15:0] limit_of(input scld_kind_e k);
    case (k)
      KIND_BLINK: return lim_now.pulse;
      KIND_FREQ:  return lim_now.freq;
      default:    return lim_now.mod;
    endcase
  endfunction

  // Decimal argument text, often at the range edges
  function automatic string arg_text(input logic [15:0] cap);
    case ($urandom_range(0, 7))
      0:       return "0";
      1:       return "1";
      2:       return $sformatf("%0d", cap);
      3:       return $sformatf("%0d", cap + 17'd1);
      4:       return $sformatf("%0d", $urandom_range(0, cap));
      5:       return $sformatf("%0d%0d", $urandom, $urandom_range(0, 999));
      6:       return $sformatf("-%0d", $urandom_range(0, 50));
      default: return $sformatf("%0d", $urandom_range(0, 65535));
    endcase
  endfunction

  function automatic string lead_space();
    case ($urandom_range(0, 4))
      0:       return " ";
      1:       return "\t";
      2:       return " \t  ";
      default: return "";
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_tx ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (b == CHAR_CR) lines_sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
    send_byte(CHAR_CR);
  endtask

  // Stop offering bytes until every result is back, then let the pipe drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] p, input logic [15:0] f,
                            input logic [15:0] m);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_PULSE_LIMIT;
    cfg_data_i  <= p;
    @(posedge clk_i);
    cfg_index_i <= REG_FREQ_LIMIT;
    cfg_data_i  <= f;
    @(posedge clk_i);
    cfg_index_i <= REG_MOD_LIMIT;
    cfg_data_i  <= m;
    @(posedge clk_i);
    // unused index must leave all limits alone
    cfg_index_i <= REG_SPARE;
    cfg_data_i  <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_now  = '{p, f, m};
    settings++;
  endtask

  task automatic send_directed();
    string pad;
    pad = "";
    send_line(" \ton");
    send_line("off");
    send_line("blink 1000");
    send_line("blink 1001");
    send_line("freq 1");
    send_line("freq 0");
    send_line("modl 0");
    send_line("modl 101");
    send_line("modl -1");
    send_line("");
    send_line(" \t ");
    send_line("freq 5 ");
    send_line("blink7");
    send_line("onx");
    send_line("of");
    send_line("freqency 12");
    send_line("blink 4294967297");  // wraps to 1
    repeat (LINE_MAX - 7) pad = {pad, " "};
    send_line({pad, "modl 7"});     // CR lands exactly on the last slot
    send_line({pad, "modl 77"});    // one byte too many
    send_byte(8'hFF);
    send_byte(CHAR_TAB);
    send_byte(8'h80);
    send_byte(CHAR_CR);
  endtask

  task automatic send_random_line();
    string      core;
    scld_kind_e k;
    int         sel;
    int         pad;
    k    = scld_kind_e'($urandom_range(KIND_ON, KIND_MODL));
    sel  = $urandom_range(0, 99);
    core = word_of(k);
    if (k >= KIND_BLINK) core = {core, " ", arg_text(limit_of(k))};
    if (sel < 55) begin
      core = {lead_space(), core};
    end else if (sel < 62) begin
      // argument glued on, or after a tab instead of a space
      core = word_of(k);
      if ($urandom_range(0, 1)) core = {core, "\t"};
      core = {core, arg_text(limit_of(k))};
    end else if (sel < 68) begin
      core = {core, " "};
    end else if (sel < 74) begin
      core = {word_of(k), "xz ", arg_text(limit_of(k))};
    end else if (sel < 80) begin
      core = word_of(k);
      if ($urandom_range(0, 1)) core = core.substr(0, core.len() - 2);
      else core = {core, "q"};
    end else if (sel < 88) begin
      pad = $urandom_range(LINE_MAX - 2, LINE_MAX + 1) - core.len();
      repeat (pad) core = {" ", core};
    end else if (sel < 92) begin
      core = lead_space();
    end else begin
      core = "";
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
    end
    send_line(core);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();

    for (int ph = 1; ph <= PHASES; ph++) begin
      wait_idle();
      case (ph)
        1:       set_limits(16'd1, 16'd1, 16'd0);
        2:       set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_limits(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                            16'($urandom_range(0, 300)));
      endcase
      steady_tx = (ph == 4);
      if (ph == 2) hold_req++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_line();
    end

    wait_idle();
    $display("Summary: %0d bytes in %0d lines sent, %0d command results checked",
             bytes_sent, lines_sent, results);
    $display("Summary: %0d limit settings incl. both extremes, one long result hold-off",
             settings);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
